>>> src/pbfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbfd_pkg: shared types and constants
// Parse phases, control states, result record and field helpers for the
// packed bytecode field decoder.
// ----------------------------------------------------------------------------
package pbfd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_OPCODE,
        PH_FTYPE,
        PH_FVAL,
        PH_STYPE,
        PH_SVAL,
        PH_LABEL,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_FIN,
        ST_FLUSH
    } state_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_OP     = 2'd1;
    localparam logic [1:0] KIND_LABEL  = 2'd2;
    localparam logic [1:0] KIND_TRUNC  = 2'd3;

    localparam logic [2:0] OPC_DUAL_LO  = 3'd0;
    localparam logic [2:0] OPC_BARE     = 3'd2;
    localparam logic [2:0] OPC_DUAL_MID = 3'd3;
    localparam logic [2:0] OPC_DUAL_HI  = 3'd4;

    localparam logic [1:0] TYPE_BYTE = 2'd0;
    localparam logic [1:0] TYPE_REG  = 2'd1;

    localparam logic [3:0] HEADER_WIDTH = 4'd5;
    localparam logic [3:0] OPCODE_WIDTH = 4'd3;
    localparam logic [3:0] TYPE_WIDTH   = 4'd2;
    localparam logic [3:0] LABEL_WIDTH  = 4'd3;

    typedef struct packed {
        logic [1:0] record_kind;
        logic [4:0] op_count;
        logic [2:0] op_code;
        logic [1:0] operand_count;
        logic [1:0] first_type;
        logic [7:0] first_value;
        logic [1:0] second_type;
        logic [7:0] second_value;
        logic [2:0] func_label;
        logic       run_end;
    } rec_t;

    typedef struct packed {
        logic bit_en;
        logic bit_in;
        logic fin;
        logic clear;
    } prs_ctl_t;

    function automatic logic [1:0] operands_of(input logic [2:0] code);
        logic [1:0] cnt;
        case (code) inside
            OPC_DUAL_LO, OPC_DUAL_MID, OPC_DUAL_HI: cnt = 2'd2;
            OPC_BARE:                               cnt = 2'd0;
            default:                                cnt = 2'd1;
        endcase
        return cnt;
    endfunction

    function automatic logic [3:0] value_width(input logic [1:0] kind);
        logic [3:0] w;
        case (kind)
            TYPE_BYTE: w = 4'd8;
            TYPE_REG:  w = 4'd3;
            default:   w = 4'd5;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> src/packed_bytecode_field_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packed_bytecode_field_decoder: packed program image decoder
// Decodes function headers, operations and labels from image bytes fed last
// byte first, one bit per cycle unless the output stalls, and flags truncation.
// ----------------------------------------------------------------------------
// Each byte is shifted through the parser one bit per clock while the bit
// stepping is not held, after the accepting state (ST_IDLE); then come the
// end-of-byte check (ST_FIN) and the release of the last record of the byte
// (ST_FLUSH). Records wait in a one-entry pending stage so the last record
// of a byte can be marked with run_end; when both that stage and the output
// register are full, the bit stepping holds until the output transaction
// completes. The next byte is taken only after all records of the current
// byte have left the pending stage.
module packed_bytecode_field_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_final,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      record_kind,
    output logic [4:0]      op_count,
    output logic [2:0]      op_code,
    output logic [1:0]      operand_count,
    output logic [1:0]      first_type,
    output logic [7:0]      first_value,
    output logic [1:0]      second_type,
    output logic [7:0]      second_value,
    output logic [2:0]      func_label,
    output logic            run_end
);

    pbfd_pkg::state_t state_reg, state_next;
    logic [7:0] byte_reg;
    logic       fin_reg;
    logic [2:0] cnt_reg;
    pbfd_pkg::rec_t pend_reg;
    logic           pend_valid_reg;
    pbfd_pkg::rec_t out_reg;
    logic           out_valid_reg;

    pbfd_pkg::prs_ctl_t ctl;
    pbfd_pkg::rec_t     prs_rec;
    logic               prs_valid;
    logic               trunc_needed;

    logic           out_free;
    logic           step_ok;
    logic           trunc_push;
    logic           push;
    pbfd_pkg::rec_t push_rec;
    pbfd_pkg::rec_t flush_rec;
    logic           flush;
    logic           in_take;

    pbfd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .rec          (prs_rec),
        .rec_valid    (prs_valid),
        .trunc_needed (trunc_needed)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign step_ok  = !pend_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_ready   = (state_reg == pbfd_pkg::ST_IDLE);
        ctl.bit_en = (state_reg == pbfd_pkg::ST_BITS) && step_ok;
        ctl.bit_in = byte_reg[0];
        ctl.fin    = fin_reg;
        ctl.clear  = (state_reg == pbfd_pkg::ST_FIN) && fin_reg &&
                     (!trunc_needed || step_ok);
        trunc_push = (state_reg == pbfd_pkg::ST_FIN) && fin_reg && trunc_needed && step_ok;
        push       = prs_valid || trunc_push;
        push_rec   = prs_rec;
        if (trunc_push)
        begin
            push_rec             = '0;
            push_rec.record_kind = pbfd_pkg::KIND_TRUNC;
        end
        flush_rec         = pend_reg;
        flush_rec.run_end = 1'b1;
        flush = (state_reg == pbfd_pkg::ST_FLUSH) && pend_valid_reg && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbfd_pkg::ST_IDLE:
            begin
                if (in_take)
                    state_next = pbfd_pkg::ST_BITS;
            end
            pbfd_pkg::ST_BITS:
            begin
                if (step_ok && cnt_reg == 3'd7)
                    state_next = pbfd_pkg::ST_FIN;
            end
            pbfd_pkg::ST_FIN:
            begin
                if (!fin_reg || !trunc_needed || step_ok)
                    state_next = pbfd_pkg::ST_FLUSH;
            end
            pbfd_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = pbfd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pbfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pbfd_pkg::ST_IDLE;
            cnt_reg        <= 3'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_take)
                cnt_reg <= 3'd0;
            else if (ctl.bit_en)
                cnt_reg <= cnt_reg + 3'd1;
            if (push)
                pend_valid_reg <= 1'b1;
            else if (flush)
                pend_valid_reg <= 1'b0;
            if ((push && pend_valid_reg) || flush)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= in_byte;
            fin_reg  <= is_final;
        end
        else if (ctl.bit_en)
        begin
            byte_reg <= {1'b0, byte_reg[7:1]};
        end
        if (push)
            pend_reg <= push_rec;
        if (push && pend_valid_reg)
        begin
            out_reg <= pend_reg;
        end
        else if (flush)
        begin
            out_reg <= flush_rec;
        end
    end

    assign out_valid     = out_valid_reg;
    assign record_kind   = out_reg.record_kind;
    assign op_count      = out_reg.op_count;
    assign op_code       = out_reg.op_code;
    assign operand_count = out_reg.operand_count;
    assign first_type    = out_reg.first_type;
    assign first_value   = out_reg.first_value;
    assign second_type   = out_reg.second_type;
    assign second_value  = out_reg.second_value;
    assign func_label    = out_reg.func_label;
    assign run_end       = out_reg.run_end;

endmodule
`default_nettype wire

>>> src/pbfd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbfd_parser: bit-serial grammar parser
// Gathers one image bit per step into the current field and, as each field
// completes, advances the grammar and reports header, operation and label
// records.
// ----------------------------------------------------------------------------
module pbfd_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pbfd_pkg::prs_ctl_t ctl,
    output pbfd_pkg::rec_t        rec,
    output logic                  rec_valid,
    output logic                  trunc_needed
);

    pbfd_pkg::phase_t phase_reg, phase_next;
    logic [7:0] store_reg, store_next;
    logic [2:0] held_reg, held_next;
    logic [4:0] ops_left_reg, ops_left_next;
    logic [2:0] opcode_reg, opcode_next;
    logic [1:0] ftype_reg, ftype_next;
    logic [7:0] fval_reg, fval_next;
    logic [1:0] stype_reg, stype_next;

    logic [3:0] width;
    logic [7:0] cur;
    logic [3:0] held_inc;
    logic       complete;
    logic [4:0] ops_dec;
    logic       do_emit;
    logic [7:0] emit_sval;

    always_comb
    begin
        unique case (phase_reg)
            pbfd_pkg::PH_HEADER: width = pbfd_pkg::HEADER_WIDTH;
            pbfd_pkg::PH_OPCODE: width = pbfd_pkg::OPCODE_WIDTH;
            pbfd_pkg::PH_FTYPE:  width = pbfd_pkg::TYPE_WIDTH;
            pbfd_pkg::PH_FVAL:   width = pbfd_pkg::value_width(ftype_reg);
            pbfd_pkg::PH_STYPE:  width = pbfd_pkg::TYPE_WIDTH;
            pbfd_pkg::PH_SVAL:   width = pbfd_pkg::value_width(stype_reg);
            default:             width = pbfd_pkg::LABEL_WIDTH;
        endcase
    end

    assign cur          = store_reg | (8'(ctl.bit_in) << held_reg);
    assign held_inc     = {1'b0, held_reg} + 4'd1;
    assign complete     = held_inc >= width;
    assign ops_dec      = ops_left_reg - 5'd1;
    assign trunc_needed = !(phase_reg == pbfd_pkg::PH_STOP ||
                            (phase_reg == pbfd_pkg::PH_HEADER && held_reg == 3'd0));

    always_comb
    begin
        phase_next    = phase_reg;
        store_next    = store_reg;
        held_next     = held_reg;
        ops_left_next = ops_left_reg;
        opcode_next   = opcode_reg;
        ftype_next    = ftype_reg;
        fval_next     = fval_reg;
        stype_next    = stype_reg;
        rec           = '0;
        rec_valid     = 1'b0;
        do_emit       = 1'b0;
        emit_sval     = 8'd0;
        if (ctl.clear)
        begin
            phase_next    = pbfd_pkg::PH_HEADER;
            store_next    = 8'd0;
            held_next     = 3'd0;
            ops_left_next = 5'd0;
            opcode_next   = 3'd0;
            ftype_next    = 2'd0;
            fval_next     = 8'd0;
            stype_next    = 2'd0;
        end
        else if (ctl.bit_en && phase_reg != pbfd_pkg::PH_STOP)
        begin
            if (phase_reg == pbfd_pkg::PH_HEADER && held_reg == 3'd0 && ctl.fin)
            begin
                phase_next = pbfd_pkg::PH_STOP;
            end
            else if (!complete)
            begin
                store_next = cur;
                held_next  = held_inc[2:0];
            end
            else
            begin
                store_next = 8'd0;
                held_next  = 3'd0;
                unique case (phase_reg)
                    pbfd_pkg::PH_HEADER:
                    begin
                        ops_left_next   = cur[4:0];
                        rec.record_kind = pbfd_pkg::KIND_HEADER;
                        rec.op_count    = cur[4:0];
                        rec_valid       = 1'b1;
                        phase_next      = (cur[4:0] != 5'd0) ? pbfd_pkg::PH_OPCODE
                                                             : pbfd_pkg::PH_LABEL;
                    end
                    pbfd_pkg::PH_OPCODE:
                    begin
                        opcode_next = cur[2:0];
                        if (pbfd_pkg::operands_of(cur[2:0]) == 2'd0)
                            do_emit = 1'b1;
                        else
                            phase_next = pbfd_pkg::PH_FTYPE;
                    end
                    pbfd_pkg::PH_FTYPE:
                    begin
                        ftype_next = cur[1:0];
                        phase_next = pbfd_pkg::PH_FVAL;
                    end
                    pbfd_pkg::PH_FVAL:
                    begin
                        fval_next = cur;
                        if (pbfd_pkg::operands_of(opcode_reg) == 2'd1)
                            do_emit = 1'b1;
                        else
                            phase_next = pbfd_pkg::PH_STYPE;
                    end
                    pbfd_pkg::PH_STYPE:
                    begin
                        stype_next = cur[1:0];
                        phase_next = pbfd_pkg::PH_SVAL;
                    end
                    pbfd_pkg::PH_SVAL:
                    begin
                        do_emit   = 1'b1;
                        emit_sval = cur;
                    end
                    pbfd_pkg::PH_LABEL:
                    begin
                        rec.record_kind = pbfd_pkg::KIND_LABEL;
                        rec.func_label  = cur[2:0];
                        rec_valid       = 1'b1;
                        phase_next      = pbfd_pkg::PH_HEADER;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
                if (do_emit)
                begin
                    rec.record_kind   = pbfd_pkg::KIND_OP;
                    rec.op_code       = opcode_next;
                    rec.operand_count = pbfd_pkg::operands_of(opcode_next);
                    if (rec.operand_count != 2'd0)
                    begin
                        rec.first_type  = ftype_next;
                        rec.first_value = fval_next;
                    end
                    if (rec.operand_count == 2'd2)
                    begin
                        rec.second_type  = stype_next;
                        rec.second_value = emit_sval;
                    end
                    rec_valid     = 1'b1;
                    opcode_next   = 3'd0;
                    ftype_next    = 2'd0;
                    fval_next     = 8'd0;
                    stype_next    = 2'd0;
                    ops_left_next = ops_dec;
                    phase_next    = (ops_dec != 5'd0) ? pbfd_pkg::PH_OPCODE
                                                      : pbfd_pkg::PH_LABEL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= pbfd_pkg::PH_HEADER;
            store_reg    <= 8'd0;
            held_reg     <= 3'd0;
            ops_left_reg <= 5'd0;
            opcode_reg   <= 3'd0;
            ftype_reg    <= 2'd0;
            fval_reg     <= 8'd0;
            stype_reg    <= 2'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            store_reg    <= store_next;
            held_reg     <= held_next;
            ops_left_reg <= ops_left_next;
            opcode_reg   <= opcode_next;
            ftype_reg    <= ftype_next;
            fval_reg     <= fval_next;
            stype_reg    <= stype_next;
        end
    end

endmodule
`default_nettype wire
